/* hw/rtl/bbc_pkg.sv */
`timescale 1ns / 1ps

package bbc_pkg;

  // Default geometry of the slot table
  localparam int unsigned SLOT_COUNT_DEF = 8;
  localparam int unsigned BLOCK_BITS_DEF = 16;

  // Fixed field widths on the ports
  localparam int unsigned BLK_W      = 16;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned SLOT_OUT_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_BLOCK  = 3'd0,
    OP_BUFFER = 3'd1,
    OP_UPDATE = 3'd2,
    OP_SAVE   = 3'd3,
    OP_FLUSH  = 3'd4
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANT     = 2'd0,
    KIND_WRITEBACK = 2'd1,
    KIND_DONE      = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_VIC_RD,
    ST_VIC_WB,
    ST_GRANT,
    ST_UPD_RD,
    ST_UPD_DONE,
    ST_SV_CHECK,
    ST_SV_WB,
    ST_SV_DONE,
    ST_ERR
  } state_e;

  // Which result the datapath loads into its output register
  typedef enum logic [2:0] {
    EM_NONE,
    EM_GRANT,
    EM_VIC_WB,
    EM_SV_WB,
    EM_UPD,
    EM_DONE,
    EM_FLUSH,
    EM_ERR
  } emit_e;

  // Address source of the tag memory read port
  typedef enum logic [1:0] {
    RD_SCAN,
    RD_VICTIM,
    RD_CURRENT
  } rd_src_e;

  typedef struct packed {
    logic    lat;
    logic    lat_fetch;
    logic    clr_scan;
    logic    adv;
    logic    rd_en;
    rd_src_e rd_src;
    logic    cmp;
    emit_e   emit;
  } cmd_t;

  typedef struct packed {
    logic blk_zero;
    logic scan_last;
    logic need_vic_wb;
    logic sv_dirty;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/bbc_ctrl.sv */
`timescale 1ns / 1ps

module bbc_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [bbc_pkg::OP_W-1:0]   operation_i,
  input  bbc_pkg::sts_t              sts_i,
  output bbc_pkg::cmd_t              cmd_o
);

  bbc_pkg::state_e state_q, state_d;
  logic            flush_q;
  bbc_pkg::op_e    op_in;

  assign op_in      = bbc_pkg::op_e'(operation_i);
  assign in_stall_o = (state_q != bbc_pkg::ST_IDLE);

  // Hold state and remember whether the save-all also empties the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbc_pkg::ST_IDLE;
      flush_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == bbc_pkg::ST_IDLE && in_valid_i) begin
        flush_q <= (op_in == bbc_pkg::OP_FLUSH);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op_in) inside
            bbc_pkg::OP_BLOCK, bbc_pkg::OP_BUFFER:
              state_d = sts_i.blk_zero ? bbc_pkg::ST_ERR : bbc_pkg::ST_SCAN;
            bbc_pkg::OP_UPDATE:
              state_d = bbc_pkg::ST_UPD_RD;
            bbc_pkg::OP_SAVE, bbc_pkg::OP_FLUSH:
              state_d = bbc_pkg::ST_SV_CHECK;
            default:
              state_d = bbc_pkg::ST_ERR;
          endcase
        end
      end
      bbc_pkg::ST_SCAN: begin
        if (sts_i.scan_last) state_d = bbc_pkg::ST_SCAN_END;
      end
      bbc_pkg::ST_SCAN_END: state_d = bbc_pkg::ST_DECIDE;
      bbc_pkg::ST_DECIDE: begin
        state_d = sts_i.need_vic_wb ? bbc_pkg::ST_VIC_RD : bbc_pkg::ST_GRANT;
      end
      bbc_pkg::ST_VIC_RD: state_d = bbc_pkg::ST_VIC_WB;
      bbc_pkg::ST_VIC_WB: begin
        if (sts_i.out_free) state_d = bbc_pkg::ST_GRANT;
      end
      bbc_pkg::ST_GRANT: begin
        if (sts_i.out_free) state_d = bbc_pkg::ST_IDLE;
      end
      bbc_pkg::ST_UPD_RD: state_d = bbc_pkg::ST_UPD_DONE;
      bbc_pkg::ST_UPD_DONE: begin
        if (sts_i.out_free) state_d = bbc_pkg::ST_IDLE;
      end
      bbc_pkg::ST_SV_CHECK: begin
        if (sts_i.sv_dirty) begin
          state_d = bbc_pkg::ST_SV_WB;
        end else if (sts_i.scan_last) begin
          state_d = bbc_pkg::ST_SV_DONE;
        end
      end
      bbc_pkg::ST_SV_WB: begin
        if (sts_i.out_free) begin
          state_d = sts_i.scan_last ? bbc_pkg::ST_SV_DONE : bbc_pkg::ST_SV_CHECK;
        end
      end
      bbc_pkg::ST_SV_DONE: begin
        if (sts_i.out_free) state_d = bbc_pkg::ST_IDLE;
      end
      bbc_pkg::ST_ERR: begin
        if (sts_i.out_free) state_d = bbc_pkg::ST_IDLE;
      end
      default: state_d = bbc_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_src = bbc_pkg::RD_SCAN;
    cmd_o.emit   = bbc_pkg::EM_NONE;
    unique case (state_q)
      bbc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.lat       = 1'b1;
          cmd_o.lat_fetch = (op_in == bbc_pkg::OP_BLOCK);
          cmd_o.clr_scan  = 1'b1;
        end
      end
      bbc_pkg::ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.cmp   = 1'b1;
        cmd_o.adv   = 1'b1;
      end
      bbc_pkg::ST_SCAN_END, bbc_pkg::ST_DECIDE, bbc_pkg::ST_UPD_DONE: begin
        if (state_q == bbc_pkg::ST_UPD_DONE && sts_i.out_free) begin
          cmd_o.emit = bbc_pkg::EM_UPD;
        end
      end
      bbc_pkg::ST_VIC_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = bbc_pkg::RD_VICTIM;
      end
      bbc_pkg::ST_VIC_WB: begin
        if (sts_i.out_free) cmd_o.emit = bbc_pkg::EM_VIC_WB;
      end
      bbc_pkg::ST_GRANT: begin
        if (sts_i.out_free) cmd_o.emit = bbc_pkg::EM_GRANT;
      end
      bbc_pkg::ST_UPD_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = bbc_pkg::RD_CURRENT;
      end
      bbc_pkg::ST_SV_CHECK: begin
        if (sts_i.sv_dirty) begin
          cmd_o.rd_en = 1'b1;
        end else if (!sts_i.scan_last) begin
          cmd_o.adv = 1'b1;
        end
      end
      bbc_pkg::ST_SV_WB: begin
        if (sts_i.out_free) begin
          cmd_o.emit = bbc_pkg::EM_SV_WB;
          cmd_o.adv  = !sts_i.scan_last;
        end
      end
      bbc_pkg::ST_SV_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = flush_q ? bbc_pkg::EM_FLUSH : bbc_pkg::EM_DONE;
        end
      end
      bbc_pkg::ST_ERR: begin
        if (sts_i.out_free) cmd_o.emit = bbc_pkg::EM_ERR;
      end
      default: cmd_o.emit = bbc_pkg::EM_NONE;
    endcase
  end

endmodule

/* hw/rtl/bbc_datapath.sv */
`timescale 1ns / 1ps

module bbc_datapath #(
  parameter int unsigned SLOT_COUNT        = bbc_pkg::SLOT_COUNT_DEF,
  parameter int unsigned BLOCK_NUMBER_BITS = bbc_pkg::BLOCK_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [bbc_pkg::BLK_W-1:0]       block_number_i,
  input  bbc_pkg::cmd_t                   cmd_i,
  output bbc_pkg::sts_t                   sts_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bbc_pkg::KIND_W-1:0]      result_kind_o,
  output logic [bbc_pkg::SLOT_OUT_W-1:0]  slot_o,
  output logic [bbc_pkg::BLK_W-1:0]       block_number_out_o,
  output logic                            fetch_needed_o,
  output logic                            last_o
);

  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
  localparam int unsigned TAG_W  =
    (BLOCK_NUMBER_BITS < bbc_pkg::BLK_W) ? BLOCK_NUMBER_BITS : bbc_pkg::BLK_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  // Tag store: contents are meaningful only where the valid bit is set
  logic [TAG_W-1:0]      tag_mem [SLOT_COUNT];
  logic [TAG_W-1:0]      tag_rd_q;
  logic [SLOT_W-1:0]     rd_addr;

  logic [SLOT_COUNT-1:0] valid_q;
  logic [SLOT_COUNT-1:0] dirty_q;
  logic [SLOT_W-1:0]     victim_q;
  logic [SLOT_W-1:0]     current_q;

  logic [SLOT_W-1:0]     scan_q;
  logic                  cmp_vld_q;
  logic [SLOT_W-1:0]     cmp_idx_q;
  logic                  hit_q;
  logic [SLOT_W-1:0]     hit_idx_q;
  logic                  empty_q;
  logic [SLOT_W-1:0]     empty_idx_q;

  logic [TAG_W-1:0]      blk_q;
  logic                  fetch_q;

  logic                  out_vld_q;
  bbc_pkg::kind_e        kind_q;
  logic [bbc_pkg::SLOT_OUT_W-1:0] slot_q;
  logic [bbc_pkg::BLK_W-1:0]      blk_out_q;
  logic                  fetch_out_q;
  logic                  last_q;

  logic                  cmp_match;
  logic                  cmp_empty;
  logic                  use_victim;
  logic [SLOT_W-1:0]     grant_slot;
  logic [SLOT_W-1:0]     victim_nxt;
  logic                  out_free;
  logic                  load;
  logic                  tag_wr;

  bbc_pkg::kind_e        kind_sel;
  logic [SLOT_W-1:0]     slot_sel;
  logic [TAG_W-1:0]      tag_sel;
  logic                  fetch_sel;
  logic                  last_sel;

  // Read address select
  always_comb begin
    case (cmd_i.rd_src)
      bbc_pkg::RD_SCAN:    rd_addr = scan_q;
      bbc_pkg::RD_VICTIM:  rd_addr = victim_q;
      bbc_pkg::RD_CURRENT: rd_addr = current_q;
      default:             rd_addr = scan_q;
    endcase
  end

  // Compare stage of the slot scan
  assign cmp_match = cmp_vld_q && valid_q[cmp_idx_q] && (tag_rd_q == blk_q);
  assign cmp_empty = cmp_vld_q && !valid_q[cmp_idx_q];

  // Slot choice: hit, then first empty slot, then round-robin victim
  assign use_victim = !hit_q && !empty_q;
  assign grant_slot = hit_q ? hit_idx_q : (empty_q ? empty_idx_q : victim_q);
  assign victim_nxt = (victim_q == LAST_SLOT) ? '0 : victim_q + 1'b1;

  assign out_free = !out_vld_q || !out_stall_i;
  assign load     = (cmd_i.emit != bbc_pkg::EM_NONE);
  assign tag_wr   = (cmd_i.emit == bbc_pkg::EM_GRANT) && !hit_q;

  // Status to the controller
  assign sts_o.blk_zero    = (block_number_i[TAG_W-1:0] == '0);
  assign sts_o.scan_last   = (scan_q == LAST_SLOT);
  assign sts_o.need_vic_wb = use_victim && dirty_q[victim_q];
  assign sts_o.sv_dirty    = dirty_q[scan_q];
  assign sts_o.out_free    = out_free;

  // Tag memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (tag_wr) begin
      tag_mem[grant_slot] <= blk_q;
    end
    if (cmd_i.rd_en) begin
      tag_rd_q <= tag_mem[rd_addr];
    end
  end

  // Capture the request and the index of the slot under compare
  always_ff @(posedge clk_i) begin
    if (cmd_i.lat) begin
      blk_q   <= block_number_i[TAG_W-1:0];
      fetch_q <= cmd_i.lat_fetch;
    end
    cmp_idx_q <= scan_q;
  end

  // Slot state, pointers and scan bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      dirty_q     <= '0;
      victim_q    <= '0;
      current_q   <= '0;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      empty_q     <= 1'b0;
      empty_idx_q <= '0;
    end else begin
      cmp_vld_q <= cmd_i.cmp;

      if (cmd_i.clr_scan) begin
        scan_q  <= '0;
        hit_q   <= 1'b0;
        empty_q <= 1'b0;
      end else begin
        if (cmd_i.adv) scan_q <= scan_q + 1'b1;
        if (cmp_match && !hit_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= cmp_idx_q;
        end
        if (cmp_empty && !empty_q) begin
          empty_q     <= 1'b1;
          empty_idx_q <= cmp_idx_q;
        end
      end

      case (cmd_i.emit)
        bbc_pkg::EM_GRANT: begin
          if (!hit_q) begin
            valid_q[grant_slot] <= 1'b1;
            dirty_q[grant_slot] <= 1'b0;
          end
          current_q <= grant_slot;
          if (use_victim) victim_q <= victim_nxt;
        end
        bbc_pkg::EM_VIC_WB: dirty_q[victim_q] <= 1'b0;
        bbc_pkg::EM_SV_WB:  dirty_q[scan_q] <= 1'b0;
        bbc_pkg::EM_UPD: begin
          if (valid_q[current_q]) dirty_q[current_q] <= 1'b1;
        end
        bbc_pkg::EM_FLUSH:  valid_q <= '0;
        default: ;
      endcase
    end
  end

  // Result field select
  always_comb begin
    kind_sel  = bbc_pkg::KIND_DONE;
    slot_sel  = '0;
    tag_sel   = '0;
    fetch_sel = 1'b0;
    last_sel  = 1'b1;
    case (cmd_i.emit)
      bbc_pkg::EM_GRANT: begin
        kind_sel  = bbc_pkg::KIND_GRANT;
        slot_sel  = grant_slot;
        tag_sel   = blk_q;
        fetch_sel = !hit_q && fetch_q;
      end
      bbc_pkg::EM_VIC_WB: begin
        kind_sel = bbc_pkg::KIND_WRITEBACK;
        slot_sel = victim_q;
        tag_sel  = tag_rd_q;
        last_sel = 1'b0;
      end
      bbc_pkg::EM_SV_WB: begin
        kind_sel = bbc_pkg::KIND_WRITEBACK;
        slot_sel = scan_q;
        tag_sel  = tag_rd_q;
        last_sel = 1'b0;
      end
      bbc_pkg::EM_UPD: begin
        slot_sel = current_q;
        tag_sel  = valid_q[current_q] ? tag_rd_q : '0;
      end
      bbc_pkg::EM_ERR: kind_sel = bbc_pkg::KIND_ERROR;
      default: ;
    endcase
  end

  // Output register: load a beat, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q      <= kind_sel;
      slot_q      <= bbc_pkg::SLOT_OUT_W'(slot_sel);
      blk_out_q   <= bbc_pkg::BLK_W'(tag_sel);
      fetch_out_q <= fetch_sel;
      last_q      <= last_sel;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign result_kind_o      = kind_q;
  assign slot_o             = slot_q;
  assign block_number_out_o = blk_out_q;
  assign fetch_needed_o     = fetch_out_q;
  assign last_o             = last_q;

endmodule

/* hw/rtl/block_buffer_cache_manager.sv */
`timescale 1ns / 1ps

// Buffer cache slot manager. Requests enter on the in channel (operation,
// block_number); results leave on the out channel as a sequence of beats,
// the final one of each request flagged by last_o. Both channels move a
// beat at a clock edge where valid is high and stall is low.
// Block/buffer requests scan the tag memory one slot per cycle, then load
// a grant, after first writing back a dirty victim when one is evicted.
// Save-all and flush walk the slots, writing back each dirty slot, then
// give the done beat. Update and error requests answer with a single beat.
// One request is in work at a time; in_stall_o is high until its last
// beat sits in the output register, and the next request is taken while
// that beat waits. A stall on the out channel holds the current beat and
// pauses the walk. Reset empties every slot, clears all dirty bits and
// the round-robin and current slot pointers; no clearing pass is needed.
module block_buffer_cache_manager #(
  parameter int unsigned SLOT_COUNT        = bbc_pkg::SLOT_COUNT_DEF,
  parameter int unsigned BLOCK_NUMBER_BITS = bbc_pkg::BLOCK_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bbc_pkg::OP_W-1:0]        operation_i,
  input  logic [bbc_pkg::BLK_W-1:0]       block_number_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bbc_pkg::KIND_W-1:0]      result_kind_o,
  output logic [bbc_pkg::SLOT_OUT_W-1:0]  slot_o,
  output logic [bbc_pkg::BLK_W-1:0]       block_number_out_o,
  output logic                            fetch_needed_o,
  output logic                            last_o
);

  bbc_pkg::cmd_t cmd;
  bbc_pkg::sts_t sts;

  bbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bbc_datapath #(
    .SLOT_COUNT        (SLOT_COUNT),
    .BLOCK_NUMBER_BITS (BLOCK_NUMBER_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .block_number_i     (block_number_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_kind_o      (result_kind_o),
    .slot_o             (slot_o),
    .block_number_out_o (block_number_out_o),
    .fetch_needed_o     (fetch_needed_o),
    .last_o             (last_o)
  );

endmodule

/* tb/tb_block_buffer_cache_manager.sv */
`timescale 1ns / 1ps

module tb_block_buffer_cache_manager;

  localparam int SLOTS       = bbc_pkg::SLOT_COUNT_DEF;
  localparam int OP_BITS     = bbc_pkg::OP_W;
  localparam int BLK_BITS    = bbc_pkg::BLK_W;
  localparam int RANDOM_REQS = 285;
  localparam int HOLDOFF_AT  = 160;
  localparam int HOLDOFF_LEN = 300;
  localparam int CALM_FROM   = 200;
  localparam int CALM_TO     = 260;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 50;

  typedef struct {
    logic [OP_BITS-1:0]  op;
    logic [BLK_BITS-1:0] blk;
    bit                  drain;
  } req_t;

  typedef struct {
    bbc_pkg::kind_e      kind;
    logic [2:0]          slot;
    logic [BLK_BITS-1:0] blk;
    logic                fetch;
    logic                last;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [OP_BITS-1:0]             operation = '0;
  logic [BLK_BITS-1:0]            block_number = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [bbc_pkg::KIND_W-1:0]     res_kind;
  logic [bbc_pkg::SLOT_OUT_W-1:0] res_slot;
  logic [BLK_BITS-1:0]            res_blk;
  logic                           res_fetch;
  logic                           res_last;

  // Requests waiting to be offered and beats the cache still owes us
  req_t  req_q[$];
  beat_t beats_due_q[$];

  int beats_owed    = 0;
  int beats_checked = 0;
  int reqs_taken    = 0;
  int fail_count    = 0;
  int quiet_cycles  = 0;
  int holdoff_left  = 0;
  bit holdoff_used  = 1'b0;
  logic calm;

  // Shadow copy of the slot table
  logic [BLK_BITS-1:0] tag_of[SLOTS];
  logic                dirty_of[SLOTS];
  int                  next_victim;
  int                  cur_slot;

  block_buffer_cache_manager dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .operation_i        (operation),
    .block_number_i     (block_number),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .result_kind_o      (res_kind),
    .slot_o             (res_slot),
    .block_number_out_o (res_blk),
    .fetch_needed_o     (res_fetch),
    .last_o             (res_last)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  assign calm = (reqs_taken >= CALM_FROM) && (reqs_taken < CALM_TO);

  function automatic void add_req(logic [OP_BITS-1:0] op, logic [BLK_BITS-1:0] blk,
                                  bit drain = 1'b0);
    req_t r;
    r.op    = op;
    r.blk   = blk;
    r.drain = drain;
    req_q.push_back(r);
  endfunction

  function automatic void owe(bbc_pkg::kind_e kind, int slot, logic [BLK_BITS-1:0] blk,
                              logic fetch, logic last);
    beat_t b;
    b.kind  = kind;
    b.slot  = slot[2:0];
    b.blk   = blk;
    b.fetch = fetch;
    b.last  = last;
    beats_due_q.push_back(b);
  endfunction

  // Advance the shadow table by one request; return the number of beats owed
  function automatic int predict_cache_step(logic [OP_BITS-1:0] op,
                                            logic [BLK_BITS-1:0] blk);
    int base_cnt;
    int hit;
    int free_slot;
    int s;
    base_cnt = beats_due_q.size();
    case (op)
      bbc_pkg::OP_BLOCK, bbc_pkg::OP_BUFFER: begin
        if (blk == '0) begin
          owe(bbc_pkg::KIND_ERROR, 0, '0, 1'b0, 1'b1);
        end else begin
          hit = -1;
          free_slot = -1;
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (tag_of[i] == blk) hit = i;
            if (tag_of[i] == '0) free_slot = i;
          end
          if (hit >= 0) begin
            cur_slot = hit;
            owe(bbc_pkg::KIND_GRANT, hit, blk, 1'b0, 1'b1);
          end else begin
            if (free_slot >= 0) begin
              s = free_slot;
            end else begin
              // Evict the round-robin victim, writing it back first if dirty
              s = next_victim;
              if (dirty_of[s]) owe(bbc_pkg::KIND_WRITEBACK, s, tag_of[s], 1'b0, 1'b0);
              next_victim = (s + 1) % SLOTS;
            end
            tag_of[s] = blk;
            dirty_of[s] = 1'b0;
            cur_slot = s;
            owe(bbc_pkg::KIND_GRANT, s, blk, op == bbc_pkg::OP_BLOCK, 1'b1);
          end
        end
      end
      bbc_pkg::OP_UPDATE: begin
        if (tag_of[cur_slot] != '0) dirty_of[cur_slot] = 1'b1;
        owe(bbc_pkg::KIND_DONE, cur_slot, tag_of[cur_slot], 1'b0, 1'b1);
      end
      bbc_pkg::OP_SAVE, bbc_pkg::OP_FLUSH: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (dirty_of[i]) owe(bbc_pkg::KIND_WRITEBACK, i, tag_of[i], 1'b0, 1'b0);
          dirty_of[i] = 1'b0;
          if (op == bbc_pkg::OP_FLUSH) tag_of[i] = '0;
        end
        owe(bbc_pkg::KIND_DONE, 0, '0, 1'b0, 1'b1);
      end
      default: begin
        owe(bbc_pkg::KIND_ERROR, 0, '0, 1'b0, 1'b1);
      end
    endcase
    return beats_due_q.size() - base_cnt;
  endfunction

  // Request driver: predict on each accepted beat, then hold, advance or idle
  always @(posedge clk_i or negedge rst_ni) begin
    logic took;
    int   added;
    req_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      operation <= '0;
      block_number <= '0;
      beats_owed <= 0;
      reqs_taken <= 0;
    end else begin
      took = in_valid && !in_stall;
      added = 0;
      if (took) begin
        added = predict_cache_step(operation, block_number);
        reqs_taken <= reqs_taken + 1;
      end
      beats_owed <= beats_owed + added;
      if (in_valid && !took) begin
        // hold the stalled beat
      end else if (req_q.size() != 0
                   && !(req_q[0].drain && (beats_owed + added != beats_checked))
                   && (calm || $urandom_range(99) >= 15)) begin
        nxt = req_q.pop_front();
        in_valid <= 1'b1;
        operation <= nxt.op;
        block_number <= nxt.blk;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: check each accepted beat, then pick the stall for next cycle
  always @(posedge clk_i or negedge rst_ni) begin
    beat_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      beats_checked <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_checked <= beats_checked + 1;
        if (beats_due_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected beat: kind %0d slot %0d blk %h fetch %b last %b",
                     res_kind, res_slot, res_blk, res_fetch, res_last);
        end else begin
          want = beats_due_q.pop_front();
          if (res_kind !== want.kind || res_slot !== want.slot || res_blk !== want.blk
              || res_fetch !== want.fetch || res_last !== want.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: exp kind %0d slot %0d blk %h fetch %b last %b",
                       want.kind, want.slot, want.blk, want.fetch, want.last);
              $display("          got kind %0d slot %0d blk %h fetch %b last %b",
                       res_kind, res_slot, res_blk, res_fetch, res_last);
            end
          end
        end
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else if (!holdoff_used && reqs_taken >= HOLDOFF_AT) begin
        // Hold off long enough for the cache to back up into its input
        holdoff_used = 1'b1;
        holdoff_left = HOLDOFF_LEN;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 15);
      end
    end
  end

  // Watchdog on cycles where neither channel moves a beat
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_block_buffer_cache_manager: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [BLK_BITS-1:0] pool[12];
    logic [BLK_BITS-1:0] blk;
    int                  pick;

    for (int i = 0; i < SLOTS; i++) begin
      tag_of[i] = '0;
      dirty_of[i] = 1'b0;
    end
    next_victim = 0;
    cur_slot = 0;

    // Errors, empty update and save, then fill the table and force dirty evictions
    add_req(bbc_pkg::OP_BLOCK, 16'h0000);
    add_req(bbc_pkg::OP_BUFFER, 16'h0000);
    add_req(3'd5, BLK_BITS'($urandom_range(65535)));
    add_req(3'd6, BLK_BITS'($urandom_range(65535)));
    add_req(3'd7, 16'hFFFF);
    add_req(bbc_pkg::OP_UPDATE, 16'h0000);
    add_req(bbc_pkg::OP_SAVE, 16'h0000);
    add_req(bbc_pkg::OP_BLOCK, 16'hFFFF);
    add_req(bbc_pkg::OP_BUFFER, 16'h0001);
    add_req(bbc_pkg::OP_BLOCK, 16'h0001);
    add_req(bbc_pkg::OP_UPDATE, 16'h0000);
    add_req(bbc_pkg::OP_BUFFER, 16'hFFFF);
    add_req(bbc_pkg::OP_UPDATE, 16'h0000);
    add_req(bbc_pkg::OP_BLOCK, 16'h8000);
    add_req(bbc_pkg::OP_BLOCK, 16'h7FFF);
    add_req(bbc_pkg::OP_BUFFER, 16'h00FF);
    add_req(bbc_pkg::OP_BLOCK, 16'hFF00);
    add_req(bbc_pkg::OP_BUFFER, 16'h5555);
    add_req(bbc_pkg::OP_BLOCK, 16'hAAAA);
    add_req(bbc_pkg::OP_UPDATE, 16'h0000);
    add_req(bbc_pkg::OP_BLOCK, 16'h1234);
    add_req(bbc_pkg::OP_BUFFER, 16'h4321);
    add_req(bbc_pkg::OP_UPDATE, 16'h0000);
    add_req(bbc_pkg::OP_SAVE, 16'h0000);
    add_req(bbc_pkg::OP_UPDATE, 16'h0000);
    add_req(bbc_pkg::OP_FLUSH, 16'h0000);
    add_req(bbc_pkg::OP_UPDATE, 16'h0000);

    // Random traffic over a small working set so hits and evictions both occur
    for (int i = 0; i < 12; i++) pool[i] = BLK_BITS'($urandom_range(65535, 1));
    for (int i = 0; i < RANDOM_REQS; i++) begin
      pick = $urandom_range(99);
      blk = ($urandom_range(99) < 75) ? pool[$urandom_range(11)]
                                      : BLK_BITS'($urandom_range(65535, 1));
      if (pick < 34) begin
        add_req(bbc_pkg::OP_BLOCK, blk, i == 60 || i == 140);
      end else if (pick < 56) begin
        add_req(bbc_pkg::OP_BUFFER, blk, i == 60 || i == 140);
      end else if (pick < 76) begin
        add_req(bbc_pkg::OP_UPDATE, BLK_BITS'($urandom_range(65535)), i == 60 || i == 140);
      end else if (pick < 82) begin
        add_req(bbc_pkg::OP_SAVE, BLK_BITS'($urandom_range(65535)), i == 60 || i == 140);
      end else if (pick < 86) begin
        add_req(bbc_pkg::OP_FLUSH, BLK_BITS'($urandom_range(65535)), i == 60 || i == 140);
      end else if (pick < 91) begin
        add_req(OP_BITS'($urandom_range(7, 5)), BLK_BITS'($urandom_range(65535)));
      end else begin
        add_req(OP_BITS'($urandom_range(1)), 16'h0000);
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: everything offered and every owed beat checked
    while (req_q.size() != 0 || in_valid || beats_owed != beats_checked) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (fail_count == 0 && beats_due_q.size() == 0) begin
      $display("tb_block_buffer_cache_manager: done, clean");
    end else begin
      $display("tb_block_buffer_cache_manager: done, errors");
    end
    $finish;
  end

endmodule
